FILE: rtl/core/ffls_pkg.sv
// ffls_pkg: types and constants shared by the flat facet Lambert shader.
// No dependencies; every rtl/core file refers to it by scoped names.
package ffls_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS + 2;
    localparam int CROSS_BITS = 2 * COORD_BITS + 3;
    localparam int MAG_BITS   = 2 * COORD_BITS + 2;
    localparam int NORM_BITS  = 31;
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int XMAG_BITS  = (MAG_BITS > NORM_BITS) ? MAG_BITS : NORM_BITS;
    localparam int SHIFT_BITS = 5;

    localparam int COUNT_BITS = 9;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 9'd64;
    localparam int SHADE_BITS = 8;
    localparam logic [9:0] SHADE_MAX = 10'd255;

    // floor(v / 10) = (v * RECIP10) >> RECIP10_SHIFT, exact for v below 2^16
    localparam int RECIP10_BITS  = 16;
    localparam logic [RECIP10_BITS-1:0] RECIP10 = 16'd52429;
    localparam int RECIP10_SHIFT = 19;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] corner_a_x;
        logic signed [COORD_BITS-1:0] corner_a_y;
        logic signed [COORD_BITS-1:0] corner_a_z;
        logic signed [COORD_BITS-1:0] corner_b_x;
        logic signed [COORD_BITS-1:0] corner_b_y;
        logic signed [COORD_BITS-1:0] corner_b_z;
        logic signed [COORD_BITS-1:0] corner_c_x;
        logic signed [COORD_BITS-1:0] corner_c_y;
        logic signed [COORD_BITS-1:0] corner_c_z;
    } t_corners;

    typedef struct packed {
        logic [SHADE_BITS-1:0] shade_index;
        logic                  degenerate;
    } t_shade;

    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

endpackage

FILE: rtl/core/ffls_front.sv
// ffls_front: edge vectors, cross product, magnitude normalize and squares.
// Six register stages. Depends on ffls_pkg.
module ffls_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  ffls_pkg::t_corners                     i_corners,
    output ffls_pkg::t_ctl                         o_ctl,
    output logic [ffls_pkg::SUM_BITS-1:0]          o_sum,
    output logic [ffls_pkg::SQ_BITS-1:0]           o_zsq
);

    localparam int DW = ffls_pkg::DIFF_BITS;
    localparam int PW = ffls_pkg::PROD_BITS;
    localparam int CW = ffls_pkg::CROSS_BITS;
    localparam int MW = ffls_pkg::MAG_BITS;
    localparam int NW = ffls_pkg::NORM_BITS;
    localparam int XW = ffls_pkg::XMAG_BITS;
    localparam int QW = ffls_pkg::SQ_BITS;
    localparam int SW = ffls_pkg::SUM_BITS;
    localparam int SHIFT_W = ffls_pkg::SHIFT_BITS;

    logic [5:0] r_vld;

    // stage 0: edge vectors
    logic signed [DW-1:0] r_d1x, r_d1y, r_d1z, r_d2x, r_d2y, r_d2z;
    // stage 1: products
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    // stage 2: magnitudes
    logic [MW-1:0] r_mx, r_my, r_mz, n_mx, n_my, n_mz;
    // stage 3: normalized
    logic [NW-1:0] r_nx, r_ny, r_nz, n_nx, n_ny, n_nz;
    logic          r_dg3, n_dg3;
    logic          r_dg4, r_dg5;
    // stage 4: squares
    logic [QW-1:0] r_sx, r_sy, r_sz;
    // stage 5: sums
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_zsq;

    logic [SHIFT_W-1:0] sh;
    logic [MW-1:0] mag_or;
    logic signed [CW-1:0] cx, cy, cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1x <= DW'(i_corners.corner_a_x) - DW'(i_corners.corner_b_x);
        r_d1y <= DW'(i_corners.corner_a_y) - DW'(i_corners.corner_b_y);
        r_d1z <= DW'(i_corners.corner_a_z) - DW'(i_corners.corner_b_z);
        r_d2x <= DW'(i_corners.corner_c_x) - DW'(i_corners.corner_b_x);
        r_d2y <= DW'(i_corners.corner_c_y) - DW'(i_corners.corner_b_y);
        r_d2z <= DW'(i_corners.corner_c_z) - DW'(i_corners.corner_b_z);

        r_p1 <= PW'(r_d2y) * PW'(r_d1z);
        r_p2 <= PW'(r_d2z) * PW'(r_d1y);
        r_p3 <= PW'(r_d2z) * PW'(r_d1x);
        r_p4 <= PW'(r_d2x) * PW'(r_d1z);
        r_p5 <= PW'(r_d2x) * PW'(r_d1y);
        r_p6 <= PW'(r_d2y) * PW'(r_d1x);

        r_mx <= n_mx;
        r_my <= n_my;
        r_mz <= n_mz;

        r_nx  <= n_nx;
        r_ny  <= n_ny;
        r_nz  <= n_nz;
        r_dg3 <= n_dg3;

        r_sx  <= QW'(r_nx) * QW'(r_nx);
        r_sy  <= QW'(r_ny) * QW'(r_ny);
        r_sz  <= QW'(r_nz) * QW'(r_nz);
        r_dg4 <= r_dg3;

        r_sum <= SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
        r_zsq <= r_sz;
        r_dg5 <= r_dg4;
    end

    always_comb begin
        cx = CW'(r_p1) - CW'(r_p2);
        cy = CW'(r_p3) - CW'(r_p4);
        cz = CW'(r_p5) - CW'(r_p6);
        n_mx = cx[CW-1] ? MW'(-cx) : MW'(cx);
        n_my = cy[CW-1] ? MW'(-cy) : MW'(cy);
        n_mz = cz[CW-1] ? MW'(-cz) : MW'(cz);
    end

    // smallest right shift that brings the largest magnitude below 2^31
    always_comb begin
        mag_or = r_mx | r_my | r_mz;
        n_dg3  = (mag_or == '0);
        sh     = '0;
        for (int i = NW; i < MW; i++) begin
            if (mag_or[i]) begin
                sh = SHIFT_W'(i - NW + 1);
            end
        end
        n_nx = NW'(XW'(r_mx) >> sh);
        n_ny = NW'(XW'(r_my) >> sh);
        n_nz = NW'(XW'(r_mz) >> sh);
    end

    assign o_ctl.valid = r_vld[5];
    assign o_ctl.degen = r_dg5;
    assign o_sum       = r_sum;
    assign o_zsq       = r_zsq;

endmodule

FILE: rtl/core/ffls_div.sv
// ffls_div: restoring divider, one quotient bit per stage: q = floor(z^2*2^(2R)/S).
// Depends on ffls_pkg.
module ffls_div #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffls_pkg::t_ctl                    i_ctl,
    input  logic [ffls_pkg::SUM_BITS-1:0]     i_sum,
    input  logic [ffls_pkg::SQ_BITS-1:0]      i_zsq,
    output ffls_pkg::t_ctl                    o_ctl,
    output logic [2*RATIO_FRAC_BITS:0]        o_quot
);

    localparam int QW = 2 * RATIO_FRAC_BITS + 1;
    localparam int SW = ffls_pkg::SUM_BITS;
    localparam int RW = SW + 1;

    logic [QW-1:0] r_vld;
    logic [QW-1:0] r_dg;
    logic [RW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [SW-1:0] r_den [QW];
    logic [RW-1:0] n_rem [QW];
    logic [QW-1:0] n_quo [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dg <= {r_dg[QW-2:0], i_ctl.degen};
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] trial;
        logic [SW-1:0] den;
        logic [QW-1:0] quo_in;

        if (k == 0) begin : g_head
            assign trial  = RW'(i_zsq);
            assign den    = i_sum;
            assign quo_in = '0;
        end else begin : g_tail
            assign trial  = {r_rem[k-1][RW-2:0], 1'b0};
            assign den    = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        always_comb begin
            n_rem[k] = trial;
            n_quo[k] = quo_in;
            if (trial >= RW'(den)) begin
                n_rem[k] = trial - RW'(den);
                n_quo[k][QW-1-k] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
            r_den[k] <= den;
        end
    end

    assign o_ctl.valid = r_vld[QW-1];
    assign o_ctl.degen = r_dg[QW-1];
    assign o_quot      = r_quo[QW-1];

endmodule

FILE: rtl/core/ffls_sqrt.sv
// ffls_sqrt: digit-by-digit integer square root, one root bit per stage.
// Depends on ffls_pkg.
module ffls_sqrt #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffls_pkg::t_ctl                i_ctl,
    input  logic [2*RATIO_FRAC_BITS:0]    i_quot,
    output ffls_pkg::t_ctl                o_ctl,
    output logic [RATIO_FRAC_BITS:0]      o_root
);

    localparam int R  = RATIO_FRAC_BITS;
    localparam int NS = R + 1;
    localparam int FW = R + 1;
    localparam int EW = R + 3;
    localparam int PW = 2 * R + 2;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_dg;
    logic [FW-1:0] r_root [NS];
    logic [EW-1:0] r_rem  [NS];
    logic [PW-1:0] r_rad  [NS];
    logic [FW-1:0] n_root [NS];
    logic [EW-1:0] n_rem  [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dg <= {r_dg[NS-2:0], i_ctl.degen};
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [FW-1:0] root_in;
        logic [EW-1:0] rem_in;
        logic [PW-1:0] rad_in;
        logic [EW-1:0] cur;
        logic [EW-1:0] trial;

        if (k == 0) begin : g_head
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = PW'(i_quot);
        end else begin : g_tail
            assign root_in = r_root[k-1];
            assign rem_in  = r_rem[k-1];
            assign rad_in  = r_rad[k-1];
        end

        always_comb begin
            cur   = {rem_in[EW-3:0], rad_in[PW-1:PW-2]};
            trial = {root_in, 2'b01};
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {root_in[FW-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {root_in[FW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[k] <= n_root[k];
            r_rem[k]  <= n_rem[k];
            r_rad[k]  <= {rad_in[PW-3:0], 2'b00};
        end
    end

    assign o_ctl.valid = r_vld[NS-1];
    assign o_ctl.degen = r_dg[NS-1];
    assign o_root      = r_root[NS-1];

endmodule

FILE: rtl/core/ffls_shade.sv
// ffls_shade: scale the Lambert factor onto the colour ramp and saturate.
// Three register stages, the last one drives the result ports. Depends on ffls_pkg.
module ffls_shade #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ffls_pkg::t_ctl                      i_ctl,
    input  logic [RATIO_FRAC_BITS:0]            i_root,
    input  logic [ffls_pkg::COUNT_BITS-1:0]     i_count,
    output logic                                o_strobe,
    output ffls_pkg::t_shade                    o_result
);

    localparam int R  = RATIO_FRAC_BITS;
    localparam int AW = R + 4;
    localparam int CB = ffls_pkg::COUNT_BITS;
    localparam int MW = AW + CB;
    localparam int VW = 13;
    localparam int KW = VW + ffls_pkg::RECIP10_BITS;
    localparam int IW = 10;

    logic [1:0]    r_vld;
    logic          r_strobe;
    logic [1:0]    r_dg;
    logic [MW-1:0] r_prod;
    logic [IW-1:0] r_tenth;
    logic [AW-1:0] scaled;
    logic [VW-1:0] v;
    logic [KW-1:0] k;
    logic [CB-1:0] lim;
    logic [IW-1:0] idx;
    ffls_pkg::t_shade r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[0], i_ctl.valid};
            r_strobe <= r_vld[1];
        end
    end

    // 7*f + 3*2^R, factor forced to zero for a degenerate normal
    always_comb begin
        if (i_ctl.degen) begin
            scaled = AW'(3) << R;
        end else begin
            scaled = (AW'(i_root) << 3) - AW'(i_root) + (AW'(3) << R);
        end
        v   = r_prod[R+VW-1:R];
        k   = KW'(v) * KW'(ffls_pkg::RECIP10);
        lim = i_count - CB'(1);
        idx = r_tenth;
        if (i_count == '0) begin
            idx = '0;
        end else if (idx > IW'(lim)) begin
            idx = IW'(lim);
        end
        if (idx > ffls_pkg::SHADE_MAX) begin
            idx = ffls_pkg::SHADE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= MW'(i_count) * MW'(scaled);
        r_tenth <= k[ffls_pkg::RECIP10_SHIFT+IW-1:ffls_pkg::RECIP10_SHIFT];
        r_dg    <= {r_dg[0], i_ctl.degen};
        r_result.shade_index <= idx[ffls_pkg::SHADE_BITS-1:0];
        r_result.degenerate  <= r_dg[1];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: rtl/core/flat_facet_lambert_shader.sv
// flat_facet_lambert_shader: top level of the flat Lambert facet shader.
// Instantiates ffls_front, ffls_div, ffls_sqrt, ffls_shade; uses ffls_pkg.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+----------------------------
//  corners  | start, busy, i_corners             | taken when start & !busy
//  result   | o_strobe, o_result                 | one cycle per item, no hold
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data | written when valid & ready
//
// One item enters every cycle; busy never rises since nothing stalls.
// The pipeline holds six front stages, one divider stage per quotient bit,
// one square root stage per root bit and three shading stages.
// Reset clears the valid bits and loads the colour count with 64.
// The receiver cannot stall, so the pipeline never holds.
module flat_facet_lambert_shader #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ffls_pkg::t_corners                  i_corners,
    output logic                                o_strobe,
    output ffls_pkg::t_shade                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffls_pkg::COUNT_BITS-1:0]     i_cfg_data
);

    localparam int R = RATIO_FRAC_BITS;

    logic [ffls_pkg::COUNT_BITS-1:0] r_colour_count;

    ffls_pkg::t_ctl front_ctl, div_ctl, sqrt_ctl;
    logic [ffls_pkg::SUM_BITS-1:0] front_sum;
    logic [ffls_pkg::SQ_BITS-1:0]  front_zsq;
    logic [2*R:0]                  div_quot;
    logic [R:0]                    sqrt_root;

    // fully pipelined, never back-pressured
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // colour count; to be written only while no item is in flight, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_count <= ffls_pkg::COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_colour_count <= i_cfg_data;
        end
    end

    // normal, normalize, S and z^2
    ffls_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_corners (i_corners),
        .o_ctl     (front_ctl),
        .o_sum     (front_sum),
        .o_zsq     (front_zsq)
    );

    // floor(z^2 * 2^(2R) / S); floor of its root is the Lambert factor
    ffls_div #(.RATIO_FRAC_BITS(R)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (front_ctl),
        .i_sum   (front_sum),
        .i_zsq   (front_zsq),
        .o_ctl   (div_ctl),
        .o_quot  (div_quot)
    );

    ffls_sqrt #(.RATIO_FRAC_BITS(R)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_quot  (div_quot),
        .o_ctl   (sqrt_ctl),
        .o_root  (sqrt_root)
    );

    // ramp index, degenerate facets drop to the ambient term
    ffls_shade #(.RATIO_FRAC_BITS(R)) u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (sqrt_ctl),
        .i_root   (sqrt_root),
        .i_count  (r_colour_count),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
